// ----- design/srr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the selective-repeat reorder receiver.
package srr_pkg;

    localparam int BLK_W  = 24;
    localparam int PAY_W  = 64;
    localparam int CNT_W  = 32;
    localparam int KIND_W = 2;

    localparam logic [BLK_W-1:0] BLK_MAX = {BLK_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK_NEW = 2'd1,
        KIND_ACK_DUP = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_READ
    } state_t;

endpackage

// ----- design/srr_slot_mod.sv -----
`timescale 1ns / 1ps
// Window slot of a block number: residue modulo WINDOW from per-byte tables, registered.
module srr_slot_mod import srr_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic                        clk,
    input  logic                        load,
    input  logic [BLK_W-1:0]            number,
    output logic [$clog2(WINDOW)-1:0]   slot
);

    localparam int SW = $clog2(WINDOW);
    localparam int TW = 256 * SW;
    localparam logic [SW+1:0] ONE_W = (SW+2)'(WINDOW);
    localparam logic [SW+1:0] TWO_W = (SW+2)'(2 * WINDOW);

    function automatic logic [TW-1:0] res_table(input int shift);
        logic [TW-1:0] t;
        t = '0;
        for (int b = 0; b < 256; b++) begin
            t[b*SW +: SW] = SW'((b << shift) % WINDOW);
        end
        return t;
    endfunction

    localparam logic [TW-1:0] TAB0 = res_table(0);
    localparam logic [TW-1:0] TAB1 = res_table(8);
    localparam logic [TW-1:0] TAB2 = res_table(16);

    logic [SW-1:0] r0;
    logic [SW-1:0] r1;
    logic [SW-1:0] r2;
    logic [SW+1:0] sum;
    logic [SW-1:0] slot_next;
    logic [SW-1:0] slot_reg;

    always_comb
    begin
        r0  = TAB0[number[7:0]   * SW +: SW];
        r1  = TAB1[number[15:8]  * SW +: SW];
        r2  = TAB2[number[23:16] * SW +: SW];
        sum = (SW+2)'(r0) + (SW+2)'(r1) + (SW+2)'(r2);
        if (sum >= TWO_W)
        begin
            slot_next = SW'(sum - TWO_W);
        end
        else if (sum >= ONE_W)
        begin
            slot_next = SW'(sum - ONE_W);
        end
        else
        begin
            slot_next = SW'(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

// ----- design/selective_repeat_reorder_receiver.sv -----
`timescale 1ns / 1ps
// Top level of the selective-repeat reorder receiver.
// Raise start with a block word for one cycle while busy is low. A duplicate or
// out-of-window block answers with one result, registered in the decide state. A new
// block answers with its in-order deliveries and then an ack: the decide state stores
// it, each delivery passes a scan and a read state (the single payload memory port
// reads one slot per delivery), and the ack follows the final scan. Results
// come one per strobe and cannot be held off; last marks the final one of a block.
// Write total_blocks only while busy is low and no result is pending.
module selective_repeat_reorder_receiver import srr_pkg::*;
#(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [BLK_W-1:0]   block_number,
    input  logic [PAY_W-1:0]   payload,
    input  logic               cfg_wr_en,
    input  logic [BLK_W-1:0]   cfg_wr_data,
    output logic               result_valid,
    output logic [KIND_W-1:0]  kind,
    output logic [BLK_W-1:0]   block_id,
    output logic [PAY_W-1:0]   data_out,
    output logic [CNT_W-1:0]   duplicates_seen,
    output logic               transfer_done,
    output logic               last
);

    localparam int SW = $clog2(WINDOW);
    localparam logic [SW-1:0] SLOT_LAST = SW'(WINDOW - 1);

    state_t                  state_reg;
    state_t                  state_next;
    logic [BLK_W-1:0]        blk_reg;
    logic [BLK_W-1:0]        blk_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] pay_next;
    logic [BLK_W-1:0]        ne_reg;
    logic [BLK_W-1:0]        ne_next;
    logic [SW-1:0]           ne_slot_reg;
    logic [SW-1:0]           ne_slot_next;
    logic [CNT_W-1:0]        dup_cnt_reg;
    logic [CNT_W-1:0]        dup_cnt_next;
    logic [BLK_W-1:0]        total_reg;
    logic [WINDOW-1:0]       valid_reg;
    logic [WINDOW-1:0]       valid_next;
    logic [PAYLOAD_BITS-1:0] mem [WINDOW];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;

    logic                    res_valid_reg;
    kind_t                   res_kind_reg;
    logic [BLK_W-1:0]        res_id_reg;
    logic [PAY_W-1:0]        res_data_reg;
    logic [CNT_W-1:0]        res_dups_reg;
    logic                    res_done_reg;
    logic                    res_last_reg;
    logic                    res_fire;
    kind_t                   res_kind_next;
    logic [BLK_W-1:0]        res_id_next;
    logic [PAY_W-1:0]        res_data_next;
    logic [CNT_W-1:0]        res_dups_next;
    logic                    res_done_next;
    logic                    res_last_next;

    logic                    accept;
    logic [SW-1:0]           slot_q;
    logic                    is_below;
    logic                    is_beyond;
    logic                    is_dup;
    logic                    head_valid;
    logic                    mem_we;
    logic                    mem_re;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    srr_slot_mod #(
        .WINDOW (WINDOW)
    ) u_slot (
        .clk    (clk),
        .load   (accept),
        .number (block_number),
        .slot   (slot_q)
    );

    assign is_below   = (blk_reg < ne_reg);
    assign is_dup     = is_below || valid_reg[slot_q];
    assign is_beyond  = ({1'b0, blk_reg} >= ({1'b0, ne_reg} + (BLK_W+1)'(WINDOW)));
    assign head_valid = valid_reg[ne_slot_reg];

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_DECIDE : ST_IDLE;
            ST_DECIDE: state_next = (is_dup || is_beyond) ? ST_IDLE : ST_SCAN;
            ST_SCAN:   state_next = head_valid ? ST_READ : ST_IDLE;
            ST_READ:   state_next = ST_SCAN;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        blk_next      = blk_reg;
        pay_next      = pay_reg;
        ne_next       = ne_reg;
        ne_slot_next  = ne_slot_reg;
        dup_cnt_next  = dup_cnt_reg;
        valid_next    = valid_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        res_fire      = 1'b0;
        res_kind_next = KIND_ACK_NEW;
        res_id_next   = blk_reg;
        res_data_next = '0;
        res_last_next = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    blk_next = block_number;
                    pay_next = payload[PAYLOAD_BITS-1:0];
                end
            end
            ST_DECIDE:
            begin
                if (is_dup)
                begin
                    if (dup_cnt_reg != CNT_MAX)
                    begin
                        dup_cnt_next = dup_cnt_reg + 1'b1;
                    end
                    res_fire      = 1'b1;
                    res_kind_next = KIND_ACK_DUP;
                end
                else if (is_beyond)
                begin
                    res_fire      = 1'b1;
                    res_kind_next = KIND_DROP;
                end
                else
                begin
                    mem_we             = 1'b1;
                    valid_next[slot_q] = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (head_valid)
                begin
                    mem_re = 1'b1;
                end
                else
                begin
                    res_fire      = 1'b1;
                    res_kind_next = KIND_ACK_NEW;
                end
            end
            ST_READ:
            begin
                valid_next[ne_slot_reg] = 1'b0;
                ne_next                 = ne_reg + 1'b1;
                if (ne_reg == BLK_MAX || ne_slot_reg == SLOT_LAST)
                begin
                    ne_slot_next = '0;
                end
                else
                begin
                    ne_slot_next = ne_slot_reg + 1'b1;
                end
                res_fire      = 1'b1;
                res_kind_next = KIND_DELIVER;
                res_id_next   = ne_reg;
                res_data_next = PAY_W'(rd_data_reg);
                res_last_next = 1'b0;
            end
            default:
            begin
                res_fire = 1'b0;
            end
        endcase
        res_dups_next = dup_cnt_next;
        res_done_next = (ne_next == total_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ne_reg        <= '0;
            ne_slot_reg   <= '0;
            dup_cnt_reg   <= '0;
            total_reg     <= '0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            ne_slot_reg   <= ne_slot_next;
            dup_cnt_reg   <= dup_cnt_next;
            valid_reg     <= valid_next;
            res_valid_reg <= res_fire;
            if (cfg_wr_en)
            begin
                total_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        pay_reg <= pay_next;
        if (res_fire)
        begin
            res_kind_reg <= res_kind_next;
            res_id_reg   <= res_id_next;
            res_data_reg <= res_data_next;
            res_dups_reg <= res_dups_next;
            res_done_reg <= res_done_next;
            res_last_reg <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_q] <= pay_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[ne_slot_reg];
        end
    end

    assign result_valid    = res_valid_reg;
    assign kind            = res_kind_reg;
    assign block_id        = res_id_reg;
    assign data_out        = res_data_reg;
    assign duplicates_seen = res_dups_reg;
    assign transfer_done   = res_done_reg;
    assign last            = res_last_reg;

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("payload memory written and read in one cycle");

    a_read_hits_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> valid_reg[ne_slot_reg])
        else $error("delivery from an empty slot");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("final word shown while block still busy");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ne_slot_reg <= SLOT_LAST)
        else $error("head slot pointer out of window");

    a_delivery_advances: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> ne_reg == $past(ne_reg) + 1'b1)
        else $error("next expected number did not advance on delivery");

endmodule
